### rtl/core/mandelbrot_orbit_period_finder_assert.svh
// assertion macros used by the checker file mopf_checker.sv
`ifndef MANDELBROT_ORBIT_PERIOD_FINDER_ASSERT_SVH
`define MANDELBROT_ORBIT_PERIOD_FINDER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define MOPF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mopf assertion failed");

// next-cycle implication, disabled while reset is low
`define MOPF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mopf assertion failed");

`endif

### rtl/core/mopf_pkg.sv
// ----------------------------------------------------------------------------
// mopf_pkg
// Types and fixed-point constants of the orbit period finder.
// ----------------------------------------------------------------------------
package mopf_pkg;

  localparam int VALUE_W = 32;
  localparam int FRAC_W  = 28;
  localparam int ITER_W  = 16;
  localparam int PROD_W  = 2 * VALUE_W;
  // floored square, next z, squared-magnitude sum
  localparam int FLR_W   = PROD_W - FRAC_W;
  localparam int NEXT_W  = FLR_W + 2;
  localparam int SUM_W   = PROD_W + 1;

  localparam logic [SUM_W-1:0]  ESC_LIMIT    = SUM_W'(1) << (2 * FRAC_W + 2);
  localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(5000);

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_MUL_XX,
    OP_MUL_YY,
    OP_MUL_XY,
    OP_MUL_NX,
    OP_MUL_NY,
    OP_FINISH
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TEST,
    ST_MUL_XX,
    ST_MUL_YY,
    ST_MUL_XY,
    ST_MUL_NX,
    ST_MUL_NY,
    ST_FINISH,
    ST_CMP,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   sel_hare;
    logic   load;
    logic   save_meet;
    logic   out_load;
    logic   out_found;
  } mopf_cmd_t;

  typedef struct packed {
    logic escape;
    logic meet;
    logic recur;
  } mopf_sts_t;

endpackage

### rtl/core/mopf_datapath.sv
// ----------------------------------------------------------------------------
// mopf_datapath
// Orbit registers, shared 32x32 multiplier and escape test for z <- z*z + c.
// ----------------------------------------------------------------------------
module mopf_datapath (
  input  logic                                clk,
  input  mopf_pkg::mopf_cmd_t                 cmd,
  output mopf_pkg::mopf_sts_t                 sts,
  input  logic signed [mopf_pkg::VALUE_W-1:0] c_real,
  input  logic signed [mopf_pkg::VALUE_W-1:0] c_imag,
  output logic signed [mopf_pkg::VALUE_W-1:0] cycle_real,
  output logic signed [mopf_pkg::VALUE_W-1:0] cycle_imag
);

  logic signed [mopf_pkg::VALUE_W-1:0] cx_r, cy_r;
  logic signed [mopf_pkg::VALUE_W-1:0] tx_r, ty_r, hx_r, hy_r, mx_r, my_r;
  logic signed [mopf_pkg::VALUE_W-1:0] out_real_r, out_imag_r;
  logic signed [mopf_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [mopf_pkg::FLR_W-1:0]   xx_r;
  logic signed [mopf_pkg::NEXT_W-1:0]  nx_r, ny_r;
  logic        [mopf_pkg::PROD_W-1:0]  sq_r;

  logic signed [mopf_pkg::VALUE_W-1:0] cur_x, cur_y, mul_a, mul_b;
  logic signed [mopf_pkg::NEXT_W-1:0]  nx_nxt, ny_nxt;
  logic        [mopf_pkg::SUM_W-1:0]   mag_sum;
  logic        [mopf_pkg::NEXT_W-mopf_pkg::VALUE_W:0] nx_top, ny_top;
  logic                                fits;

  assign cur_x = cmd.sel_hare ? hx_r : tx_r;
  assign cur_y = cmd.sel_hare ? hy_r : ty_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      mopf_pkg::OP_MUL_XX: begin
        mul_a = cur_x;
        mul_b = cur_x;
      end
      mopf_pkg::OP_MUL_YY: begin
        mul_a = cur_y;
        mul_b = cur_y;
      end
      mopf_pkg::OP_MUL_XY: begin
        mul_a = cur_x;
        mul_b = cur_y;
      end
      mopf_pkg::OP_MUL_NX: begin
        mul_a = $signed(nx_r[mopf_pkg::VALUE_W-1:0]);
        mul_b = $signed(nx_r[mopf_pkg::VALUE_W-1:0]);
      end
      mopf_pkg::OP_MUL_NY: begin
        mul_a = $signed(ny_r[mopf_pkg::VALUE_W-1:0]);
        mul_b = $signed(ny_r[mopf_pkg::VALUE_W-1:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // floor(x*x) - floor(y*y) + cx, with y*y sitting in the product register
  assign nx_nxt = mopf_pkg::NEXT_W'(xx_r)
                - mopf_pkg::NEXT_W'($signed(prod_r[mopf_pkg::PROD_W-1:mopf_pkg::FRAC_W]))
                + mopf_pkg::NEXT_W'(cx_r);
  // floor(2*x*y) + cy
  assign ny_nxt = mopf_pkg::NEXT_W'($signed(prod_r[mopf_pkg::PROD_W-1:mopf_pkg::FRAC_W-1]))
                + mopf_pkg::NEXT_W'(cy_r);

  assign nx_top = nx_r[mopf_pkg::NEXT_W-1:mopf_pkg::VALUE_W-1];
  assign ny_top = ny_r[mopf_pkg::NEXT_W-1:mopf_pkg::VALUE_W-1];
  assign fits   = ((&nx_top) || !(|nx_top)) && ((&ny_top) || !(|ny_top));

  // squares are never negative, so both terms add as unsigned
  assign mag_sum = mopf_pkg::SUM_W'(sq_r) + mopf_pkg::SUM_W'($unsigned(prod_r));

  always_comb begin
    sts.escape = !fits || (mag_sum > mopf_pkg::ESC_LIMIT);
    sts.meet   = (tx_r == hx_r) && (ty_r == hy_r);
    sts.recur  = (tx_r == mx_r) && (ty_r == my_r);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.load) begin
      cx_r <= c_real;
      cy_r <= c_imag;
      tx_r <= '0;
      ty_r <= '0;
      hx_r <= '0;
      hy_r <= '0;
    end
    case (cmd.op)
      mopf_pkg::OP_MUL_YY: xx_r <= $signed(prod_r[mopf_pkg::PROD_W-1:mopf_pkg::FRAC_W]);
      mopf_pkg::OP_MUL_XY: nx_r <= nx_nxt;
      mopf_pkg::OP_MUL_NX: ny_r <= ny_nxt;
      mopf_pkg::OP_MUL_NY: sq_r <= $unsigned(prod_r);
      mopf_pkg::OP_FINISH: begin
        if (cmd.sel_hare) begin
          hx_r <= $signed(nx_r[mopf_pkg::VALUE_W-1:0]);
          hy_r <= $signed(ny_r[mopf_pkg::VALUE_W-1:0]);
        end else begin
          tx_r <= $signed(nx_r[mopf_pkg::VALUE_W-1:0]);
          ty_r <= $signed(ny_r[mopf_pkg::VALUE_W-1:0]);
        end
      end
      default: begin
      end
    endcase
    if (cmd.save_meet) begin
      mx_r <= tx_r;
      my_r <= ty_r;
    end
    if (cmd.out_load) begin
      out_real_r <= cmd.out_found ? mx_r : '0;
      out_imag_r <= cmd.out_found ? my_r : '0;
    end
  end

  assign cycle_real = out_real_r;
  assign cycle_imag = out_imag_r;

endmodule

### rtl/core/mopf_ctrl.sv
// ----------------------------------------------------------------------------
// mopf_ctrl
// Sequencer for detection rounds and period measurement, limit register,
// handshakes and result flags.
// ----------------------------------------------------------------------------
module mopf_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_found,
  output logic [mopf_pkg::ITER_W-1:0]        out_period,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mopf_pkg::ITER_W-1:0]        cfg_max_iterations,
  output mopf_pkg::mopf_cmd_t                cmd,
  input  mopf_pkg::mopf_sts_t                sts
);

  mopf_pkg::ctl_state_t state_r, state_nxt;

  logic [mopf_pkg::ITER_W-1:0] max_iter_r, max_iter_nxt;
  logic [mopf_pkg::ITER_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]                  step_idx_r, step_idx_nxt;
  logic                        measuring_r, measuring_nxt;
  logic                        hit_r, hit_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_found_r, out_found_nxt;
  logic [mopf_pkg::ITER_W-1:0] out_period_r, out_period_nxt;

  logic in_take, out_free;

  assign in_take  = in_valid && (state_r == mopf_pkg::ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mopf_pkg::ST_IDLE:   if (in_valid) state_nxt = mopf_pkg::ST_TEST;
      mopf_pkg::ST_TEST: begin
        if (cnt_r >= max_iter_r) state_nxt = mopf_pkg::ST_DONE;
        else state_nxt = mopf_pkg::ST_MUL_XX;
      end
      mopf_pkg::ST_MUL_XX: state_nxt = mopf_pkg::ST_MUL_YY;
      mopf_pkg::ST_MUL_YY: state_nxt = mopf_pkg::ST_MUL_XY;
      mopf_pkg::ST_MUL_XY: state_nxt = mopf_pkg::ST_MUL_NX;
      mopf_pkg::ST_MUL_NX: state_nxt = mopf_pkg::ST_MUL_NY;
      mopf_pkg::ST_MUL_NY: state_nxt = mopf_pkg::ST_FINISH;
      mopf_pkg::ST_FINISH: begin
        if (sts.escape) state_nxt = mopf_pkg::ST_DONE;
        else if (measuring_r || step_idx_r == 2'd2) state_nxt = mopf_pkg::ST_CMP;
        else state_nxt = mopf_pkg::ST_MUL_XX;
      end
      mopf_pkg::ST_CMP: begin
        if (measuring_r && sts.recur) state_nxt = mopf_pkg::ST_DONE;
        else state_nxt = mopf_pkg::ST_TEST;
      end
      mopf_pkg::ST_DONE:   if (out_free) state_nxt = mopf_pkg::ST_IDLE;
      default:             state_nxt = mopf_pkg::ST_IDLE;
    endcase
  end

  // counters, flags and result word
  always_comb begin
    max_iter_nxt   = max_iter_r;
    cnt_nxt        = cnt_r;
    step_idx_nxt   = step_idx_r;
    measuring_nxt  = measuring_r;
    hit_nxt        = hit_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_found_nxt  = out_found_r;
    out_period_nxt = out_period_r;
    if (cfg_valid && cfg_ready) max_iter_nxt = cfg_max_iterations;
    case (state_r)
      mopf_pkg::ST_IDLE: begin
        if (in_valid) begin
          cnt_nxt       = '0;
          measuring_nxt = 1'b0;
          hit_nxt       = 1'b0;
        end
      end
      mopf_pkg::ST_TEST: step_idx_nxt = 2'd0;
      mopf_pkg::ST_FINISH: begin
        if (!sts.escape) begin
          if (measuring_r || step_idx_r == 2'd2) cnt_nxt = cnt_r + 1'b1;
          else step_idx_nxt = step_idx_r + 1'b1;
        end
      end
      mopf_pkg::ST_CMP: begin
        if (measuring_r) begin
          if (sts.recur) hit_nxt = 1'b1;
        end else if (sts.meet) begin
          measuring_nxt = 1'b1;
          cnt_nxt       = '0;
        end
      end
      mopf_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = hit_r;
          out_period_nxt = hit_r ? cnt_r : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // datapath commands and handshake outputs
  always_comb begin
    cmd.op        = mopf_pkg::OP_IDLE;
    cmd.sel_hare  = !measuring_r && (step_idx_r != 2'd0);
    cmd.load      = in_take;
    cmd.save_meet = (state_r == mopf_pkg::ST_CMP) && !measuring_r && sts.meet;
    cmd.out_load  = (state_r == mopf_pkg::ST_DONE) && out_free;
    cmd.out_found = hit_r;
    case (state_r)
      mopf_pkg::ST_MUL_XX: cmd.op = mopf_pkg::OP_MUL_XX;
      mopf_pkg::ST_MUL_YY: cmd.op = mopf_pkg::OP_MUL_YY;
      mopf_pkg::ST_MUL_XY: cmd.op = mopf_pkg::OP_MUL_XY;
      mopf_pkg::ST_MUL_NX: cmd.op = mopf_pkg::OP_MUL_NX;
      mopf_pkg::ST_MUL_NY: cmd.op = mopf_pkg::OP_MUL_NY;
      mopf_pkg::ST_FINISH: cmd.op = mopf_pkg::OP_FINISH;
      default:             cmd.op = mopf_pkg::OP_IDLE;
    endcase
    in_stall  = (state_r != mopf_pkg::ST_IDLE);
    cfg_ready = (state_r == mopf_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mopf_pkg::ST_IDLE;
      max_iter_r   <= mopf_pkg::MAX_ITER_RST;
      cnt_r        <= '0;
      step_idx_r   <= '0;
      measuring_r  <= 1'b0;
      hit_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      max_iter_r   <= max_iter_nxt;
      cnt_r        <= cnt_nxt;
      step_idx_r   <= step_idx_nxt;
      measuring_r  <= measuring_nxt;
      hit_r        <= hit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r  <= out_found_nxt;
    out_period_r <= out_period_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_found  = out_found_r;
  assign out_period = out_period_r;

endmodule

### rtl/core/mandelbrot_orbit_period_finder.sv
// each detection round runs a limit test, three orbit steps (tortoise, then hare twice) and
// a compare, each period step a limit test, one orbit step and a compare; the result is then
// loaded into the output register, after a last limit test when a limit runs out; the load also
// waits while a result sits on out_stall; each orbit step uses the one shared 32x32 multiplier
// (5 products per step); one word at a time, the next taken once the result is in the output
// register, even while that result waits on out_stall; reset: rst_n sync, sets max_iterations 5000
// ----------------------------------------------------------------------------
// mandelbrot_orbit_period_finder
// Finds the period of the orbit of z <- z*z + c by tortoise and hare search.
// ----------------------------------------------------------------------------
module mandelbrot_orbit_period_finder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mopf_pkg::VALUE_W-1:0] in_c_real,
  input  logic signed [mopf_pkg::VALUE_W-1:0] in_c_imag,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_found,
  output logic [mopf_pkg::ITER_W-1:0]         out_period,
  output logic signed [mopf_pkg::VALUE_W-1:0] out_cycle_real,
  output logic signed [mopf_pkg::VALUE_W-1:0] out_cycle_imag,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mopf_pkg::ITER_W-1:0]         cfg_max_iterations
);

  mopf_pkg::mopf_cmd_t cmd;
  mopf_pkg::mopf_sts_t sts;

  mopf_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_found          (out_found),
    .out_period         (out_period),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_max_iterations (cfg_max_iterations),
    .cmd                (cmd),
    .sts                (sts)
  );

  mopf_datapath u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .sts        (sts),
    .c_real     (in_c_real),
    .c_imag     (in_c_imag),
    .cycle_real (out_cycle_real),
    .cycle_imag (out_cycle_imag)
  );

endmodule

### rtl/core/mopf_checker.sv
// ----------------------------------------------------------------------------
// mopf_checker
// Port-level checks of the orbit period finder, bound to the top level.
// ----------------------------------------------------------------------------
`include "mandelbrot_orbit_period_finder_assert.svh"

module mopf_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                out_found,
  input logic [mopf_pkg::ITER_W-1:0]         out_period,
  input logic signed [mopf_pkg::VALUE_W-1:0] out_cycle_real,
  input logic signed [mopf_pkg::VALUE_W-1:0] out_cycle_imag,
  input logic                                cfg_ready
);

  // a stalled result word holds
  `MOPF_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable({out_found, out_period, out_cycle_real, out_cycle_imag}))

  // no cycle found means zero period and zero meeting point
  `MOPF_ASSERT_NOW(a_miss_zero, out_valid && !out_found,
    out_period == '0 && out_cycle_real == '0 && out_cycle_imag == '0)

  // a found cycle has a period of at least one
  `MOPF_ASSERT_NOW(a_hit_period, out_valid && out_found, out_period != '0)

  // once a word is taken, the search runs with in_stall high and cfg_ready low
  `MOPF_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall && cfg_ready == 1'b0)

endmodule

bind mandelbrot_orbit_period_finder mopf_checker u_mopf_checker (.*);
